// ===== hdl/skt_pkg.sv =====
// skt_pkg: shared types and codes for the sorted key table
// entry layout, cell command struct, mode, status and cell operation codes
// no dependencies
`default_nettype none

package skt_pkg;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] mask;
  } skt_entry_t;

  // input modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // cell operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  typedef struct packed {
    logic        cmp_en;
    logic        apply_en;
    logic [1:0]  op;
    logic [15:0] key;
    logic [15:0] mask;
  } skt_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_key_table.sv =====
// sorted_key_table: top level of the sorted key table
// a row of skt_cell slots driven by a small compare/apply sequencer
// depends on skt_pkg and skt_cell
//
// usage
// - input channel (in_valid/in_ready): one item is one operation, in_mode
//   selects add, update or delete, in_key is the handle, in_event_mask the mask
// - result channel (out_valid/out_ready): exactly one item per operation,
//   out_status (ok, duplicate or absent, full) and out_entry_count afterwards
// - each item goes through accept, a compare pass in which every cell
//   flags its key against the broadcast key, and an apply pass in which the
//   cells keep, shift from a neighbour or load the new entry all together
// - the result is registered when the apply pass commits; in_ready returns
//   with it, so one item is in flight and a new item waits for that commit
// - if the receiver stalls, the result holds in the output register; a new
//   item may still be accepted and compared, but its apply pass waits until
//   the output register is free, so no result is lost or overwritten
// - reset clears the entry count and the sequencer; the cell contents are
//   not cleared, slots at or above the count are never treated as occupied
`default_nettype none

module sorted_key_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_key,
  input  wire logic [15:0] in_event_mask,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [6:0]       out_entry_count
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [15:0]      key_r;
  logic [15:0]      mask_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [6:0]       out_count_r;

  skt_cmd_t         cmd;
  skt_entry_t       entries [CAPACITY];
  logic [CAPACITY-1:0] lt_flags;
  logic [CAPACITY-1:0] eq_flags;

  logic       accept;
  logic       commit;
  logic       hit;
  logic       full;
  logic [1:0] op;
  logic [1:0] status;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // apply only when the output register can take the result
  assign commit   = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // keys are unique, so at most one cell matches
  assign hit  = |eq_flags;
  assign full = (count_r == CNT_W'(CAPACITY));

  // decide the cell operation and the status from the registered flags
  always_comb begin
    op        = OP_NONE;
    status    = STAT_MISS;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_ADD: begin
        if (hit) begin
          status = STAT_MISS;
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          op        = OP_INSERT;
          status    = STAT_OK;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_UPDATE: begin
        if (hit) begin
          op     = OP_UPDATE;
          status = STAT_OK;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          op        = OP_DELETE;
          status    = STAT_OK;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ; // unused mode, reported as a miss
    endcase
  end

  // broadcast command to the row
  assign cmd.cmp_en   = (state_r == S_CMP);
  assign cmd.apply_en = commit;
  assign cmd.op       = op;
  assign cmd.key      = key_r;
  assign cmd.mask     = mask_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      mask_r <= in_event_mask;
    end
    if (commit) begin
      out_status_r <= status;
      out_count_r  <= 7'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // the cell row: slot 0 holds the smallest key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_lt;
    skt_entry_t left_entry;
    skt_entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_lt    = lt_flags[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    skt_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk           (clk),
      .cmd_i         (cmd),
      .count_i       (count_r),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .lt_o          (lt_flags[i]),
      .eq_o          (eq_flags[i])
    );
  end

  // count never runs past the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // keys are unique, so the compare pass matches at most one cell
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $onehot0(eq_flags))
    else $error("more than one cell matched the key");

  // a successful add grows the table by one
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && mode_r == MODE_ADD && status == STAT_OK) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("add did not grow the entry count");

  // a rejected or missed operation leaves the count alone
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && status != STAT_OK) |=> $stable(count_r))
    else $error("count changed on a refused operation");

  // an accepted item always enters the compare pass next
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CMP))
    else $error("accepted item did not start its compare pass");

endmodule

`default_nettype wire

// ===== hdl/skt_cell.sv =====
// skt_cell: one slot of the sorted key table row
// holds one entry, compares it against the broadcast key, shifts to/from neighbours
// depends on skt_pkg
`default_nettype none

module skt_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                 clk,
  input  wire skt_pkg::skt_cmd_t    cmd_i,
  input  wire logic [CNT_W-1:0]     count_i,
  input  wire logic                 left_lt_i,
  input  wire skt_pkg::skt_entry_t  left_entry_i,
  input  wire skt_pkg::skt_entry_t  right_entry_i,
  output skt_pkg::skt_entry_t       entry_o,
  output logic                      lt_o,
  output logic                      eq_o
);
  import skt_pkg::*;

  skt_entry_t entry_r, entry_nxt, new_entry;
  logic       lt_r, eq_r;
  logic       occ;

  assign occ       = count_i > CNT_W'(INDEX);
  assign new_entry = '{key: cmd_i.key, mask: cmd_i.mask};

  always_ff @(posedge clk) begin
    if (cmd_i.cmp_en) begin
      lt_r <= occ && (entry_r.key < cmd_i.key);
      eq_r <= occ && (entry_r.key == cmd_i.key);
    end
  end

  // lt flags form a thermometer, so the first non-lt cell is the insert point
  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.apply_en) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (!lt_r) entry_nxt = left_lt_i ? new_entry : left_entry_i;
        end
        OP_UPDATE: begin
          if (eq_r) entry_nxt = new_entry;
        end
        OP_DELETE: begin
          if (!lt_r) entry_nxt = right_entry_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign lt_o    = lt_r;
  assign eq_o    = eq_r;

endmodule

`default_nettype wire
